FILE: rtl/core/b2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_pkg
// Shared types, constants and digit pattern functions for the binary to
// Roman numeral core.
// ----------------------------------------------------------------------------
package b2r_pkg;

  // Widths fixed by the beat fields
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned LETTER_W    = 3;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned INPUT_BITS_DEF = 16;

  // Letter codes
  localparam logic [LETTER_W-1:0] LTR_I = 3'd0;
  localparam logic [LETTER_W-1:0] LTR_X = 3'd2;
  localparam logic [LETTER_W-1:0] LTR_C = 3'd4;

  // Letter roles inside one decimal place
  localparam logic [1:0] ROLE_ONE  = 2'd0;
  localparam logic [1:0] ROLE_FIVE = 2'd1;
  localparam logic [1:0] ROLE_TEN  = 2'd2;

  // Decimal places, emitted hundreds first
  localparam logic [1:0] PLACE_HUND  = 2'd0;
  localparam logic [1:0] PLACE_TENS  = 2'd1;
  localparam logic [1:0] PLACE_UNITS = 2'd2;

  // Three BCD digits of value mod 1000
  typedef struct packed {
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } b2r_bcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } b2r_state_e;

  // Number of letters for one digit
  function automatic logic [2:0] pat_len(input logic [DIGIT_W-1:0] d);
    logic [2:0] len;
    case (d)
      4'd0:    len = 3'd0;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      default: len = 3'd2;
    endcase
    return len;
  endfunction

  // Role of letter n within the pattern of digit d
  function automatic logic [1:0] pat_role(input logic [DIGIT_W-1:0] d,
                                          input logic [1:0]         n);
    logic [1:0] role;
    role = ROLE_ONE;
    case (d)
      4'd4: begin
        if (n == 2'd1) role = ROLE_FIVE;
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        if (n == 2'd0) role = ROLE_FIVE;
      end
      4'd0, 4'd1, 4'd2, 4'd3: begin
        role = ROLE_ONE;
      end
      default: begin
        // nine: one then ten
        if (n == 2'd1) role = ROLE_TEN;
      end
    endcase
    return role;
  endfunction

endpackage

FILE: rtl/core/b2r_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_dabble
// Iterative shift-and-add-3 converter: one input bit per cycle into three
// BCD digits. Carries out of the hundreds digit are dropped, so the digits
// hold the value mod 1000.
// ----------------------------------------------------------------------------
module b2r_dabble #(
  parameter int unsigned INPUT_BITS = b2r_pkg::INPUT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [INPUT_BITS-1:0] value_i,
  output logic                 done_o,
  output b2r_pkg::b2r_bcd_t    digits_o
);

  localparam int unsigned CNT_W = $clog2(INPUT_BITS + 1);
  localparam int unsigned BCD_W = 3 * b2r_pkg::DIGIT_W;

  logic [INPUT_BITS-1:0] sh_q, sh_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      else adj[i*4 +: 4] = bcd_q[i*4 +: 4];
    end
  end

  // Step control
  always_comb begin
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (load_i) begin
      sh_d  = value_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      sh_d  = sh_q << 1;
      bcd_d = {adj[BCD_W-2:0], sh_q[INPUT_BITS-1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(INPUT_BITS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = b2r_pkg::b2r_bcd_t'(bcd_q);

endmodule

FILE: rtl/core/binary_to_roman_numeral_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_core
// Converts one unsigned value per beat into the Roman letters of its
// hundreds, tens and units digits, one letter per result beat.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake      | fields
//  ---------+-----------+----------------+------------------------------------
//  command  | in        | start & !busy  | bits_value_i
//  result   | out       | strobe_o       | roman_letter_o, letter_valid_o,
//           |           |                | run_last_o, decimal_value_o
//
// The accept edge loads the shift-and-add-3 unit, which shifts in all
// INPUT_BITS input bits and then signals done; the sequencer then emits one
// beat per letter, passing over each zero digit before the last letter.
// busy stays high until the sequencer is back in idle; the last beat shows in
// the first idle cycle, where a new command can already be accepted.
// Reset clears the sequencer and the strobe; the payload registers and the stored value are not reset.
// Results cannot be held off; each shows for exactly one cycle.
// ----------------------------------------------------------------------------
module binary_to_roman_numeral_core #(
  parameter int unsigned INPUT_BITS = b2r_pkg::INPUT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [b2r_pkg::VALUE_W-1:0]     bits_value_i,
  output logic                            strobe_o,
  output logic [b2r_pkg::LETTER_W-1:0]    roman_letter_o,
  output logic                            letter_valid_o,
  output logic                            run_last_o,
  output logic [b2r_pkg::VALUE_W-1:0]     decimal_value_o
);

  b2r_pkg::b2r_state_e state_q, state_d;
  b2r_pkg::b2r_bcd_t   digits;

  logic [INPUT_BITS-1:0]          val_q;
  logic [INPUT_BITS-1:0]          in_ext;
  logic                           accept;
  logic                           conv_done;
  logic [1:0]                     place_q, place_d;
  logic [1:0]                     n_q, n_d;
  logic [b2r_pkg::DIGIT_W-1:0]    cur_digit;
  logic [2:0]                     cur_len;
  logic [1:0]                     cur_role;
  logic [b2r_pkg::LETTER_W-1:0]   one_code;
  logic                           rest_zero;
  logic                           tail_zero;
  logic                           is_last;

  logic                           strobe_q, strobe_d;
  logic [b2r_pkg::LETTER_W-1:0]   letter_q, letter_d;
  logic                           valid_q, valid_d;
  logic                           last_q, last_d;

  assign accept = start && (state_q == b2r_pkg::ST_IDLE);
  assign busy   = (state_q != b2r_pkg::ST_IDLE);
  assign in_ext = INPUT_BITS'(bits_value_i);

  b2r_dabble #(
    .INPUT_BITS (INPUT_BITS)
  ) u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .value_i  (in_ext),
    .done_o   (conv_done),
    .digits_o (digits)
  );

  // Digit select and letter lookup for the current place
  always_comb begin
    case (place_q)
      b2r_pkg::PLACE_HUND: begin
        cur_digit = digits.hund;
        one_code  = b2r_pkg::LTR_C;
        tail_zero = (digits.tens == '0) && (digits.units == '0);
      end
      b2r_pkg::PLACE_TENS: begin
        cur_digit = digits.tens;
        one_code  = b2r_pkg::LTR_X;
        tail_zero = (digits.units == '0);
      end
      default: begin
        cur_digit = digits.units;
        one_code  = b2r_pkg::LTR_I;
        tail_zero = 1'b1;
      end
    endcase
  end

  assign cur_len   = b2r_pkg::pat_len(cur_digit);
  assign cur_role  = b2r_pkg::pat_role(cur_digit, n_q);
  assign rest_zero = (digits == '0);
  assign is_last   = ({1'b0, n_q} == cur_len - 3'd1) && tail_zero;

  // Sequencer: next state and result beat
  always_comb begin
    state_d  = state_q;
    place_d  = place_q;
    n_d      = n_q;
    strobe_d = 1'b0;
    letter_d = letter_q;
    valid_d  = valid_q;
    last_d   = last_q;
    case (state_q)
      b2r_pkg::ST_IDLE: begin
        if (start) state_d = b2r_pkg::ST_CONV;
      end
      b2r_pkg::ST_CONV: begin
        if (conv_done) begin
          state_d = b2r_pkg::ST_EMIT;
          place_d = b2r_pkg::PLACE_HUND;
          n_d     = 2'd0;
        end
      end
      b2r_pkg::ST_EMIT: begin
        if (rest_zero) begin
          // empty numeral: one beat, no letter
          strobe_d = 1'b1;
          letter_d = b2r_pkg::LTR_I;
          valid_d  = 1'b0;
          last_d   = 1'b1;
          state_d  = b2r_pkg::ST_IDLE;
        end else if ({1'b0, n_q} >= cur_len) begin
          // zero digit: move on
          place_d = place_q + 2'd1;
          n_d     = 2'd0;
        end else begin
          strobe_d = 1'b1;
          letter_d = one_code + b2r_pkg::LETTER_W'(cur_role);
          valid_d  = 1'b1;
          last_d   = is_last;
          if (is_last) begin
            state_d = b2r_pkg::ST_IDLE;
          end else if ({1'b0, n_q} == cur_len - 3'd1) begin
            place_d = place_q + 2'd1;
            n_d     = 2'd0;
          end else begin
            n_d = n_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = b2r_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= b2r_pkg::ST_IDLE;
      place_q  <= b2r_pkg::PLACE_HUND;
      n_q      <= 2'd0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      place_q  <= place_d;
      n_q      <= n_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
    valid_q  <= valid_d;
    last_q   <= last_d;
    if (accept) val_q <= in_ext;
  end

  assign strobe_o        = strobe_q;
  assign roman_letter_o  = letter_q;
  assign letter_valid_o  = valid_q;
  assign run_last_o      = last_q;
  assign decimal_value_o = b2r_pkg::VALUE_W'(val_q);

endmodule

FILE: rtl/core/b2r_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_checker
// Port-level checks on the Roman numeral core, bound to binary_to_roman_numeral_core.
// ----------------------------------------------------------------------------
module b2r_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         strobe_o,
  input logic [b2r_pkg::LETTER_W-1:0] roman_letter_o,
  input logic                         letter_valid_o,
  input logic                         run_last_o
);

  // An accepted command makes the core busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("core not busy after accepted command");

  // A beat with no letter closes its run
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !letter_valid_o |-> run_last_o)
    else $error("empty numeral beat without last flag");

  // Letter codes stay within I..M
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && letter_valid_o |-> roman_letter_o <= 3'd6)
    else $error("letter code out of range");

  // Mid-run beats come while the core is still busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !run_last_o |-> busy)
    else $error("non-final beat while idle");

  // The first cycle of a new command shows no result beat
  a_rise_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !strobe_o)
    else $error("result beat right after command accept");

endmodule

bind binary_to_roman_numeral_core b2r_checker u_b2r_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .strobe_o       (strobe_o),
  .roman_letter_o (roman_letter_o),
  .letter_valid_o (letter_valid_o),
  .run_last_o     (run_last_o)
);
